>>> design/ipr_pkg.sv
// Shared types and codes for the IPv4 route table lookup block.
package ipr_pkg;

  // Request codes
  localparam logic [1:0] REQ_DEFAULT = 2'd0;
  localparam logic [1:0] REQ_ADD     = 2'd1;
  localparam logic [1:0] REQ_DELETE  = 2'd2;
  localparam logic [1:0] REQ_FIND    = 2'd3;

  // Response status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] addr;
    logic [31:0] net_mask;
    logic [31:0] gateway;
  } ipr_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_hop;
    logic        is_direct;
  } ipr_rsp_t;

  typedef struct packed {
    logic [31:0] network;
    logic [31:0] mask;
    logic [31:0] gateway;
  } ipr_entry_t;

  // Table read address select
  typedef enum logic [1:0] {
    RD_IDX,
    RD_NEXT,
    RD_ZERO
  } ipr_rd_e;

  // Table write source select
  typedef enum logic [1:0] {
    WR_DEFAULT,
    WR_ADD,
    WR_SHIFT
  } ipr_wr_e;

  // Response source select
  typedef enum logic [2:0] {
    RES_OK,
    RES_FULL,
    RES_MISS,
    RES_DIRECT,
    RES_HIT,
    RES_DFLT
  } ipr_res_e;

  typedef struct packed {
    logic     capture;
    logic     idx_init;
    logic     idx_inc;
    logic     rd_en;
    ipr_rd_e  rd_sel;
    logic     wr_en;
    ipr_wr_e  wr_sel;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     cnt_set1;
    logic     res_en;
    ipr_res_e res_sel;
    logic     out_load;
  } ipr_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       cnt_zero;
    logic       cnt_full;
    logic       idx_end;
    logic       nxt_end;
    logic       find_hit;
    logic       del_hit;
    logic       out_free;
  } ipr_sts_t;

endpackage

>>> design/ipr_ctrl.sv
// Request sequencer for the route table: dispatch, scan, shift and reply.
module ipr_ctrl import ipr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ipr_sts_t sts_i,
  output ipr_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_DFLT = 3'd4;
  localparam logic [2:0] S_SHRD = 3'd5;
  localparam logic [2:0] S_SHWR = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_q, state_d;
  logic       is_find;

  assign is_find    = (sts_i.req_type == REQ_FIND);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel  = RD_IDX;
    cmd_o.wr_sel  = WR_DEFAULT;
    cmd_o.res_sel = RES_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.req_type)
          REQ_DEFAULT: begin
            cmd_o.wr_en    = 1'b1;
            cmd_o.wr_sel   = WR_DEFAULT;
            cmd_o.cnt_set1 = sts_i.cnt_zero;
            cmd_o.res_en   = 1'b1;
            cmd_o.res_sel  = RES_OK;
            state_d        = S_DONE;
          end
          REQ_ADD: begin
            cmd_o.res_en = 1'b1;
            if (sts_i.cnt_full) begin
              cmd_o.res_sel = RES_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wr_sel  = WR_ADD;
              cmd_o.cnt_inc = 1'b1;
              cmd_o.res_sel = RES_OK;
            end
            state_d = S_DONE;
          end
          REQ_DELETE: begin
            cmd_o.idx_init = 1'b1;
            state_d        = S_SCAN;
          end
          default: begin
            if (sts_i.cnt_zero) begin
              cmd_o.res_en  = 1'b1;
              cmd_o.res_sel = RES_DIRECT;
              state_d       = S_DONE;
            end else begin
              cmd_o.idx_init = 1'b1;
              state_d        = S_SCAN;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.idx_end) begin
          if (is_find) begin
            // no route matched: fall back to slot 0
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_ZERO;
            state_d      = S_DFLT;
          end else begin
            cmd_o.res_en  = 1'b1;
            cmd_o.res_sel = RES_MISS;
            state_d       = S_DONE;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_CMP;
        end
      end
      S_CMP: begin
        if (is_find) begin
          if (sts_i.find_hit) begin
            cmd_o.res_en  = 1'b1;
            cmd_o.res_sel = RES_HIT;
            state_d       = S_DONE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SCAN;
          end
        end else begin
          if (sts_i.del_hit) begin
            state_d = S_SHRD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SCAN;
          end
        end
      end
      S_DFLT: begin
        cmd_o.res_en  = 1'b1;
        cmd_o.res_sel = RES_DFLT;
        state_d       = S_DONE;
      end
      S_SHRD: begin
        if (sts_i.nxt_end) begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.res_en  = 1'b1;
          cmd_o.res_sel = RES_OK;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_SHWR;
        end
      end
      S_SHWR: begin
        // move the entry above down into the gap
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_SHIFT;
        cmd_o.idx_inc = 1'b1;
        state_d       = S_SHRD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/ipr_dp.sv
// Route table datapath: request register, entry memory, scan index and response registers.
module ipr_dp import ipr_pkg::*; #(
  parameter int unsigned MAX_ROUTES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ipr_req_t in_req_i,
  input  ipr_cmd_t cmd_i,
  output ipr_sts_t sts_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output ipr_rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(MAX_ROUTES + 1);
  localparam int unsigned IW = $clog2(MAX_ROUTES);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ROUTES);
  localparam logic [CW-1:0] One    = CW'(1);

  ipr_req_t   req_q;
  logic [CW-1:0] cnt_q, idx_q;
  ipr_entry_t mem_q [MAX_ROUTES];
  ipr_entry_t rd_q;
  ipr_rsp_t   res_q, res_d;
  ipr_rsp_t   out_q;
  logic       out_valid_q;

  logic [CW-1:0] idx_nxt;
  logic [IW-1:0] rd_addr, wr_addr;
  ipr_entry_t    wr_data;

  assign idx_nxt = idx_q + One;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:  rd_addr = idx_q[IW-1:0];
      RD_NEXT: rd_addr = idx_nxt[IW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_ADD: begin
        wr_addr = cnt_q[IW-1:0];
        wr_data = '{network: req_q.addr & req_q.net_mask,
                    mask:    req_q.net_mask,
                    gateway: req_q.gateway};
      end
      WR_SHIFT: begin
        wr_addr = idx_q[IW-1:0];
        wr_data = rd_q;
      end
      default: begin
        wr_addr = '0;
        wr_data = '{network: 32'd0, mask: 32'd0, gateway: req_q.gateway};
      end
    endcase
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_set1) begin
      cnt_q <= One;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + One;
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - One;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.idx_init) begin
      idx_q <= One;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_nxt;
    end
  end

  always_comb begin
    case (cmd_i.res_sel)
      RES_FULL:   res_d = '{status: ST_FULL, next_hop: 32'd0, is_direct: 1'b0};
      RES_MISS:   res_d = '{status: ST_NOT_FOUND, next_hop: 32'd0, is_direct: 1'b0};
      RES_DIRECT: res_d = '{status: ST_OK, next_hop: req_q.addr, is_direct: 1'b1};
      RES_HIT: begin
        // zero gateway means the destination is on an attached network
        if (rd_q.gateway == 32'd0) begin
          res_d = '{status: ST_OK, next_hop: req_q.addr, is_direct: 1'b1};
        end else begin
          res_d = '{status: ST_OK, next_hop: rd_q.gateway, is_direct: 1'b0};
        end
      end
      RES_DFLT:   res_d = '{status: ST_OK, next_hop: rd_q.gateway, is_direct: 1'b0};
      default:    res_d = '{status: ST_OK, next_hop: 32'd0, is_direct: 1'b0};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_en) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign sts_o.req_type = req_q.req_type;
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_full = (cnt_q >= MaxCnt);
  assign sts_o.idx_end  = (idx_q >= cnt_q);
  assign sts_o.nxt_end  = ({1'b0, idx_q} + {1'b0, One}) >= {1'b0, cnt_q};
  assign sts_o.find_hit = ((req_q.addr & rd_q.mask) == rd_q.network);
  assign sts_o.del_hit  = (rd_q.network == req_q.addr) &&
                          (rd_q.mask == req_q.net_mask) &&
                          (rd_q.gateway == req_q.gateway);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

>>> design/ip_route_table_lookup.sv
// IPv4 route table with first-match next-hop lookup.
//
// Requests arrive on in_valid_i/in_ready_o as ipr_req_t: set default gateway,
// add route, delete route, or find next hop. Each request yields exactly one
// response on out_valid_o/out_ready_i as ipr_rsp_t, in request order.
// One request is in progress at a time; in_ready_o is high only while idle.
// Set-default and add answer straight from dispatch, as does find on an empty
// table; find and delete scan the table slot by slot, find falls back to the
// default gateway in slot 0 when no route matches, and delete moves each later
// slot down by one. The scan pace is set by the single read port of the entry
// memory and its registered read data. The next request is accepted in the
// cycle after the response is loaded, at the earliest.
// The response sits in an output register; a stalled receiver holds it there,
// and the next request may be accepted and worked on meanwhile, waiting only
// to hand over its own response.
// Reset clears the route count (table empty) and all handshake state; the
// entry memory keeps no reset value and is only read at written slots.
module ip_route_table_lookup import ipr_pkg::*; #(
  parameter int unsigned MAX_ROUTES = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ipr_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ipr_rsp_t out_rsp_o
);

  ipr_cmd_t cmd;
  ipr_sts_t sts;

  ipr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ipr_dp #(
    .MAX_ROUTES (MAX_ROUTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

`ifndef ASSERT_OFF
  // a new request is never taken back to back
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous one in progress");

  // failures carry no next hop
  a_fail_no_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status != ST_OK) |->
      (out_rsp_o.next_hop == 32'd0) && !out_rsp_o.is_direct)
    else $error("failed response carries a next hop");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == ST_OK) || (out_rsp_o.status == ST_FULL) ||
                    (out_rsp_o.status == ST_NOT_FOUND))
    else $error("illegal response status");
`endif

endmodule

>>> bench/ip_route_table_lookup_test.sv
// Self-checking testbench for the IPv4 route table: directed and random requests, predicted responses.
`timescale 1ns / 1ps

module ip_route_table_lookup_test;
  import ipr_pkg::*;

  localparam int unsigned MAX_ROUTES   = 8;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned DRAIN_CYCLES = 4 * MAX_ROUTES + 16;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  ipr_req_t in_req;
  logic     out_valid;
  logic     out_ready;
  ipr_rsp_t out_rsp;

  ip_route_table_lookup #(.MAX_ROUTES(MAX_ROUTES)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp)
  );

  // Shadow copy of the route table
  logic [31:0] rt_network [MAX_ROUTES];
  logic [31:0] rt_mask    [MAX_ROUTES];
  logic [31:0] rt_gateway [MAX_ROUTES];
  int unsigned rt_count;

  ipr_rsp_t    pending_rsp_q[$];
  ipr_rsp_t    rsp_want;
  int unsigned fail_cnt;
  bit          idle_off;
  int unsigned stall_left;

  int unsigned n_find, n_direct, n_add, n_full, n_del, n_del_miss, n_dflt;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d responses outstanding",
             CYCLE_LIMIT, pending_rsp_q.size());
    $display("FAIL");
    $finish;
  end

  function automatic logic [31:0] prefix_mask(int unsigned len);
    if (len == 0) return 32'h0;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic ipr_req_t mk_req(logic [1:0] kind, logic [31:0] a, logic [31:0] m,
                                      logic [31:0] g);
    ipr_req_t r;
    r.req_type = kind;
    r.addr     = a;
    r.net_mask = m;
    r.gateway  = g;
    return r;
  endfunction

  // Next-hop prediction; updates the shadow table as the block would.
  function automatic ipr_rsp_t route_table_predict(ipr_req_t r);
    ipr_rsp_t    rsp;
    int          hit;
    int unsigned i;
    rsp = '0;
    rsp.status = ST_OK;
    hit = -1;
    case (r.req_type)
      REQ_DEFAULT: begin
        n_dflt++;
        rt_network[0] = 32'h0;
        rt_mask[0]    = 32'h0;
        rt_gateway[0] = r.gateway;
        if (rt_count == 0) rt_count = 1;
      end
      REQ_ADD: begin
        n_add++;
        if (rt_count >= MAX_ROUTES) begin
          rsp.status = ST_FULL;
          n_full++;
        end else begin
          rt_network[rt_count] = r.addr & r.net_mask;
          rt_mask[rt_count]    = r.net_mask;
          rt_gateway[rt_count] = r.gateway;
          rt_count++;
        end
      end
      REQ_DELETE: begin
        n_del++;
        for (i = 1; i < rt_count; i++)
          if (hit < 0 && rt_network[i] == r.addr && rt_mask[i] == r.net_mask &&
              rt_gateway[i] == r.gateway)
            hit = i;
        if (hit >= 0) begin
          for (i = hit; i + 1 < rt_count; i++) begin
            rt_network[i] = rt_network[i+1];
            rt_mask[i]    = rt_mask[i+1];
            rt_gateway[i] = rt_gateway[i+1];
          end
          rt_count--;
        end else begin
          rsp.status = ST_NOT_FOUND;
          n_del_miss++;
        end
      end
      default: begin
        n_find++;
        if (rt_count == 0) begin
          rsp.next_hop  = r.addr;
          rsp.is_direct = 1'b1;
        end else begin
          for (i = 1; i < rt_count; i++)
            if (hit < 0 && (r.addr & rt_mask[i]) == rt_network[i])
              hit = i;
          if (hit < 0) begin
            rsp.next_hop = rt_gateway[0];
          end else if (rt_gateway[hit] == 32'h0) begin
            rsp.next_hop  = r.addr;
            rsp.is_direct = 1'b1;
          end else begin
            rsp.next_hop = rt_gateway[hit];
          end
        end
        if (rsp.is_direct) n_direct++;
      end
    endcase
    return rsp;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(int unsigned idle_pct);
    int unsigned p;
    if (idle_off) return 0;
    p = $urandom_range(0, 99);
    if (p >= idle_pct) return 0;
    p = $urandom_range(0, 99);
    if (p < 75) return $urandom_range(1, 3);
    if (p < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(ipr_req_t r);
    int unsigned gap;
    gap = pick_gap(45);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    pending_rsp_q.push_back(route_table_predict(r));
  endtask

  // Request shaped by the current table so that hits and exact deletes are common
  function automatic ipr_req_t random_req();
    ipr_req_t    r;
    int unsigned pick, sel, idx, bitpos;
    r.addr     = $urandom;
    r.net_mask = ($urandom_range(0, 4) == 0) ? $urandom : prefix_mask($urandom_range(0, 32));
    r.gateway  = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    if (rt_count == MAX_ROUTES && pick >= 35 && pick < 60 && $urandom_range(0, 3) != 0)
      pick = 70;
    if (pick < 35) begin
      r.req_type = REQ_FIND;
      if (sel < 6 && rt_count > 1) begin
        idx = $urandom_range(1, rt_count - 1);
        r.addr = rt_network[idx] | ($urandom & ~rt_mask[idx]);
      end else if (sel == 6) begin
        r.addr = 32'h0;
      end else if (sel == 7) begin
        r.addr = 32'hFFFF_FFFF;
      end
    end else if (pick < 60) begin
      r.req_type = REQ_ADD;
      if (sel == 0) r.addr = 32'hFFFF_FFFF;
    end else if (pick < 88) begin
      r.req_type = REQ_DELETE;
      if (sel < 7 && rt_count > 1) begin
        idx = $urandom_range(1, rt_count - 1);
        r.addr     = rt_network[idx];
        r.net_mask = rt_mask[idx];
        r.gateway  = rt_gateway[idx];
        // near miss: one bit off in one field
        if (sel == 6) begin
          bitpos = $urandom_range(0, 31);
          case ($urandom_range(0, 2))
            0:       r.addr[bitpos]     = ~r.addr[bitpos];
            1:       r.net_mask[bitpos] = ~r.net_mask[bitpos];
            default: r.gateway[bitpos]  = ~r.gateway[bitpos];
          endcase
        end
      end else if (sel == 7) begin
        // the default slot itself can never be deleted
        r.addr     = 32'h0;
        r.net_mask = 32'h0;
        r.gateway  = rt_gateway[0];
      end
    end else begin
      r.req_type = REQ_DEFAULT;
    end
    return r;
  endfunction

  task automatic test_empty_table();
    send_req(mk_req(REQ_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0));
    // add into an empty table lands in the default slot
    send_req(mk_req(REQ_ADD, 32'h0A12_3456, 32'hFF00_0000, 32'h0102_0304));
    send_req(mk_req(REQ_FIND, 32'h0A00_0001, 32'h0, 32'h0));
    send_req(mk_req(REQ_DEFAULT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    send_req(mk_req(REQ_FIND, 32'h0, 32'h0, 32'h0));
  endtask

  task automatic test_fill_and_full();
    send_req(mk_req(REQ_ADD, 32'hC0A8_0155, 32'hFFFF_FF00, 32'h0));
    send_req(mk_req(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_req(mk_req(REQ_ADD, 32'hAC10_0000, 32'hFFF0_0000, 32'h5555_AAAA));
    send_req(mk_req(REQ_ADD, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001));
    send_req(mk_req(REQ_ADD, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h1111_1111));
    send_req(mk_req(REQ_ADD, 32'h7F00_0000, 32'hFF00_0000, 32'h8000_0000));
    send_req(mk_req(REQ_ADD, 32'h1234_5678, 32'h0, 32'hDEAD_BEEF));
    send_req(mk_req(REQ_ADD, 32'h0101_0101, 32'hFFFF_FFFF, 32'h0202_0202));
  endtask

  task automatic test_find_cases();
    send_req(mk_req(REQ_FIND, 32'hC0A8_01FE, 32'h0, 32'h0));
    send_req(mk_req(REQ_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0));
    send_req(mk_req(REQ_FIND, 32'h0800_0808, 32'h0, 32'h0));
  endtask

  task automatic test_delete_shift();
    send_req(mk_req(REQ_DELETE, 32'h0, 32'h0, 32'h0));
    // unmasked network does not match the stored one
    send_req(mk_req(REQ_DELETE, 32'hC0A8_0155, 32'hFFFF_FF00, 32'h0));
    send_req(mk_req(REQ_DELETE, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0));
    send_req(mk_req(REQ_FIND, 32'hC0A8_01FE, 32'h0, 32'h0));
    send_req(mk_req(REQ_ADD, 32'h0A0A_0000, 32'hFFFF_0000, 32'h0));
    send_req(mk_req(REQ_DEFAULT, 32'h0, 32'h0, 32'hAAAA_5555));
    send_req(mk_req(REQ_DELETE, 32'h0, 32'h0, 32'hDEAD_BEEF));
    send_req(mk_req(REQ_FIND, 32'h7E00_0001, 32'h0, 32'h0));
  endtask

  task automatic test_random_traffic(int unsigned n_req);
    repeat (n_req) send_req(random_req());
  endtask

  task automatic test_back_to_back(int unsigned n_req);
    idle_off = 1'b1;
    repeat (n_req) send_req(random_req());
    idle_off = 1'b0;
  endtask

  // Response checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_rsp_q.size() == 0) begin
        $error("response with nothing outstanding: status %0d next_hop %08h",
               out_rsp.status, out_rsp.next_hop);
        fail_cnt++;
      end else begin
        rsp_want = pending_rsp_q.pop_front();
        if (out_rsp.status !== rsp_want.status) begin
          $error("status: expected %0d, got %0d", rsp_want.status, out_rsp.status);
          fail_cnt++;
        end
        if (out_rsp.next_hop !== rsp_want.next_hop) begin
          $error("next_hop: expected %08h, got %08h", rsp_want.next_hop, out_rsp.next_hop);
          fail_cnt++;
        end
        if (out_rsp.is_direct !== rsp_want.is_direct) begin
          $error("is_direct: expected %0d, got %0d", rsp_want.is_direct, out_rsp.is_direct);
          fail_cnt++;
        end
      end
    end
  end

  // Receiver backpressure
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready  <= 1'b1;
        stall_left = pick_gap(20);
      end
    end
  end

  initial begin
    in_valid   = 1'b0;
    in_req     = '0;
    rst_n      = 1'b0;
    rt_count   = 0;
    fail_cnt   = 0;
    idle_off   = 1'b0;
    for (int i = 0; i < MAX_ROUTES; i++) begin
      rt_network[i] = '0;
      rt_mask[i]    = '0;
      rt_gateway[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_fill_and_full();
    test_find_cases();
    test_delete_shift();
    test_random_traffic(1900);
    test_back_to_back(100);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d finds (%0d direct), %0d adds (%0d on a full table)",
             n_find, n_direct, n_add, n_full);
    $display("covered %0d deletes (%0d not found), %0d default gateway writes, %0d errors",
             n_del, n_del_miss, n_dflt, fail_cnt);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/ipr_pkg.sv
design/ipr_ctrl.sv
design/ipr_dp.sv
design/ip_route_table_lookup.sv
bench/ip_route_table_lookup_test.sv
